// ===== design/scbpa_pkg.sv =====
// scbpa_pkg: shared constants, codes and helpers for the size-class block pool allocator
// used by size_class_block_pool_allocator and scbpa_checker; depends on nothing

package scbpa_pkg;

   // fixed field widths
   localparam int ADDR_W      = 24;
   localparam int SIZE_W      = 16;
   localparam int LOG2_W      = 4;
   localparam int COUNT_W     = 4;
   localparam int HDR_W       = 4;
   localparam int CLASS_W     = 2;
   localparam int STATUS_W    = 3;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 24;

   // parameter defaults
   localparam int NUM_CLASSES_DEF = 3;
   localparam int MAX_BLOCKS_DEF  = 8;

   // classes that own registers; any further class is empty
   localparam int CFG_CLASSES = 3;

   // block size log2 is clamped to this range
   localparam int LOG2_MIN = 3;
   localparam int LOG2_MAX = 12;

   // register reset values
   localparam logic [HDR_W-1:0]  RST_HEADER = HDR_W'(8);
   localparam logic [ADDR_W-1:0] RST_BASE   = '0;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 3'd0,
      STATUS_EMPTY       = 3'd1,
      STATUS_TOO_LARGE   = 3'd2,
      STATUS_BAD_FREE    = 3'd3,
      STATUS_DOUBLE_FREE = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLASS0_LOG2  = 4'd0,
      CSR_CLASS1_LOG2  = 4'd1,
      CSR_CLASS2_LOG2  = 4'd2,
      CSR_CLASS0_COUNT = 4'd3,
      CSR_CLASS1_COUNT = 4'd4,
      CSR_CLASS2_COUNT = 4'd5,
      CSR_HEADER       = 4'd6,
      CSR_BASE         = 4'd7
   } csr_index_type;

   function automatic logic [LOG2_W-1:0] rst_log2(input int c);
      logic [LOG2_W-1:0] r;
      unique case (c)
         0:       r = LOG2_W'(4);
         1:       r = LOG2_W'(5);
         default: r = LOG2_W'(6);
      endcase
      return r;
   endfunction

   function automatic logic [COUNT_W-1:0] rst_count(input int c);
      logic [COUNT_W-1:0] r;
      unique case (c)
         0:       r = COUNT_W'(8);
         1:       r = COUNT_W'(8);
         default: r = COUNT_W'(4);
      endcase
      return r;
   endfunction

   function automatic logic [LOG2_W-1:0] clamp_log2(input logic [LOG2_W-1:0] v);
      logic [LOG2_W-1:0] r;
      r = v;
      if (v < LOG2_W'(LOG2_MIN)) begin
         r = LOG2_W'(LOG2_MIN);
      end else if (v > LOG2_W'(LOG2_MAX)) begin
         r = LOG2_W'(LOG2_MAX);
      end
      return r;
   endfunction

endpackage

// ===== design/size_class_block_pool_allocator.sv =====
// size_class_block_pool_allocator: segregated free-list allocator over pools of fixed blocks
// depends on scbpa_pkg
//
// usage
//   request channel: a word is taken on a rising edge with start high and busy low.
//     req_kind selects allocate or free; req_size is used by allocate and
//     req_free_address by free
//   response channel: every request gives exactly one word, shown for one cycle
//     with rsp_valid high; the receiver cannot stall, so nothing is held back
//   path: a taken request goes through the input register, then the result
//     register, whose output is the response word
//   throughput: one request per cycle while busy is low; the pop or push of the chosen class
//     stack lands at the same edge as the result, so a following request sees it
//   config: csr_ready is always high; a write to a known register index refills
//     every free stack in the next cycle, busy is high for that one cycle
//   reset: registers go to their reset values and one refill cycle follows,
//     during which busy is high and no request is taken
//   block limit: one request per cycle is set by the single pass through class
//     match, stack top read and address add between the two registers

module size_class_block_pool_allocator #(
   parameter int NUM_CLASSES = scbpa_pkg::NUM_CLASSES_DEF,
   parameter int MAX_BLOCKS  = scbpa_pkg::MAX_BLOCKS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_kind,
   input  logic [scbpa_pkg::SIZE_W-1:0]       req_size,
   input  logic [scbpa_pkg::ADDR_W-1:0]       req_free_address,
   // response channel
   output logic                               rsp_valid,
   output logic [scbpa_pkg::ADDR_W-1:0]       rsp_payload_address,
   output logic [scbpa_pkg::CLASS_W-1:0]      rsp_class_used,
   output logic [scbpa_pkg::STATUS_W-1:0]     rsp_status,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [scbpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scbpa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int TOP_W  = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   // total pool span: classes * blocks * largest block
   localparam int SPAN_W = TOP_W + scbpa_pkg::LOG2_MAX + $clog2(NUM_CLASSES + 1);
   localparam int LO_W   = SPAN_W + 1;
   localparam int CMP_W  = (LO_W > scbpa_pkg::ADDR_W) ? LO_W : scbpa_pkg::ADDR_W;
   localparam int FIT_W  = scbpa_pkg::SIZE_W + 1;
   localparam int MASK_W = scbpa_pkg::LOG2_MAX;

   // configuration registers
   logic [scbpa_pkg::LOG2_W-1:0]  log2_cfg_ff  [scbpa_pkg::CFG_CLASSES];
   logic [scbpa_pkg::COUNT_W-1:0] count_cfg_ff [scbpa_pkg::CFG_CLASSES];
   logic [scbpa_pkg::HDR_W-1:0]   hdr_ff;
   logic [scbpa_pkg::ADDR_W-1:0]  base_ff;
   logic                          refill_ff;
   logic                          refill_in;
   logic                          csr_write;

   // per-class layout, loaded on refill
   logic [scbpa_pkg::LOG2_W-1:0]  lg_ff       [NUM_CLASSES];
   logic [TOP_W-1:0]              n_ff        [NUM_CLASSES];
   logic [SPAN_W-1:0]             span_ff     [NUM_CLASSES];
   logic [LO_W-1:0]               lo_ff       [NUM_CLASSES];
   logic [scbpa_pkg::ADDR_W-1:0]  pay_base_ff [NUM_CLASSES];

   logic [scbpa_pkg::LOG2_W-1:0]  lg_eff      [NUM_CLASSES];
   logic [TOP_W-1:0]              n_eff       [NUM_CLASSES];
   logic [SPAN_W-1:0]             span_in     [NUM_CLASSES];
   logic [LO_W-1:0]               lo_in       [NUM_CLASSES];
   logic [scbpa_pkg::ADDR_W-1:0]  pay_base_in [NUM_CLASSES];

   // free stacks
   logic [IDX_W-1:0]              stack_ff [NUM_CLASSES][MAX_BLOCKS];
   logic [TOP_W-1:0]              top_ff   [NUM_CLASSES];

   // input register
   logic                          in_valid_ff;
   logic                          kind_ff;
   logic [scbpa_pkg::SIZE_W-1:0]  size_ff;
   logic [scbpa_pkg::ADDR_W-1:0]  faddr_ff;

   // result register
   logic                          rsp_valid_ff;
   logic [scbpa_pkg::ADDR_W-1:0]  pay_out_ff;
   logic [scbpa_pkg::CLASS_W-1:0] cls_out_ff;
   scbpa_pkg::status_type         status_out_ff;
   logic [scbpa_pkg::ADDR_W-1:0]  pay_out_in;
   logic [scbpa_pkg::CLASS_W-1:0] cls_out_in;
   scbpa_pkg::status_type         status_out_in;

   // per-class match terms
   logic [NUM_CLASSES-1:0]        fit_w;
   logic [NUM_CLASSES-1:0]        hit_w;
   logic [NUM_CLASSES-1:0]        full_w;
   logic [NUM_CLASSES-1:0]        empty_w;
   logic [NUM_CLASSES-1:0]        pop_sel;
   logic [NUM_CLASSES-1:0]        push_sel;
   logic [scbpa_pkg::ADDR_W-1:0]  pay_w  [NUM_CLASSES];
   logic [IDX_W-1:0]              fidx_w [NUM_CLASSES];
   logic [scbpa_pkg::ADDR_W-1:0]  offset;
   logic                          found;

   assign busy      = refill_ff;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // any write to a known register starts a refill
   assign refill_in = csr_write && (csr_index <= scbpa_pkg::CSR_BASE);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < scbpa_pkg::CFG_CLASSES; c++) begin
            log2_cfg_ff[c]  <= scbpa_pkg::rst_log2(c);
            count_cfg_ff[c] <= scbpa_pkg::rst_count(c);
         end
         hdr_ff    <= scbpa_pkg::RST_HEADER;
         base_ff   <= scbpa_pkg::RST_BASE;
         refill_ff <= 1'b1;
      end else begin
         refill_ff <= refill_in;
         if (csr_write) begin
            unique case (csr_index)
               scbpa_pkg::CSR_CLASS0_LOG2:  log2_cfg_ff[0]  <= csr_wdata[scbpa_pkg::LOG2_W-1:0];
               scbpa_pkg::CSR_CLASS1_LOG2:  log2_cfg_ff[1]  <= csr_wdata[scbpa_pkg::LOG2_W-1:0];
               scbpa_pkg::CSR_CLASS2_LOG2:  log2_cfg_ff[2]  <= csr_wdata[scbpa_pkg::LOG2_W-1:0];
               scbpa_pkg::CSR_CLASS0_COUNT: count_cfg_ff[0] <= csr_wdata[scbpa_pkg::COUNT_W-1:0];
               scbpa_pkg::CSR_CLASS1_COUNT: count_cfg_ff[1] <= csr_wdata[scbpa_pkg::COUNT_W-1:0];
               scbpa_pkg::CSR_CLASS2_COUNT: count_cfg_ff[2] <= csr_wdata[scbpa_pkg::COUNT_W-1:0];
               scbpa_pkg::CSR_HEADER:       hdr_ff          <= csr_wdata[scbpa_pkg::HDR_W-1:0];
               scbpa_pkg::CSR_BASE:         base_ff         <= csr_wdata[scbpa_pkg::ADDR_W-1:0];
               default: ; // unknown index: ignored, no refill
            endcase
         end
      end
   end

   // effective size and count per class; classes past the registered ones are empty
   for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_eff
      if (g < scbpa_pkg::CFG_CLASSES) begin : g_cfg
         assign lg_eff[g] = scbpa_pkg::clamp_log2(log2_cfg_ff[g]);
         assign n_eff[g]  = (int'(count_cfg_ff[g]) > MAX_BLOCKS) ? TOP_W'(MAX_BLOCKS)
                                                                 : TOP_W'(count_cfg_ff[g]);
      end else begin : g_none
         assign lg_eff[g] = scbpa_pkg::LOG2_W'(scbpa_pkg::LOG2_MIN);
         assign n_eff[g]  = '0;
      end
   end

   // pool layout: running start of each class, short chain over the classes
   always_comb begin
      logic [SPAN_W-1:0] acc;
      acc = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         span_in[c]     = SPAN_W'(n_eff[c]) << lg_eff[c];
         lo_in[c]       = LO_W'(acc) + LO_W'(hdr_ff);
         pay_base_in[c] = base_ff + scbpa_pkg::ADDR_W'(lo_in[c]);
         acc            = acc + span_in[c];
      end
   end

   // request input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         kind_ff  <= req_kind;
         size_ff  <= req_size;
         faddr_ff <= req_free_address;
      end
   end

   assign offset = faddr_ff - base_ff;

   // per-class terms, all classes side by side
   for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cls
      logic [TOP_W-1:0]  pop_t;
      logic [IDX_W-1:0]  pop_idx;
      logic [CMP_W-1:0]  rel;
      logic [MASK_W-1:0] mask;
      logic              ge;
      logic              inr;
      logic              aligned;

      assign fit_w[g] = ({1'b0, size_ff} + FIT_W'(hdr_ff)) <= (FIT_W'(1) << lg_ff[g]);
      assign empty_w[g] = (top_ff[g] == '0);
      assign full_w[g]  = (top_ff[g] >= n_ff[g]);

      // pop side
      assign pop_t    = top_ff[g] - TOP_W'(1);
      assign pop_idx  = stack_ff[g][pop_t[IDX_W-1:0]];
      assign pay_w[g] = pay_base_ff[g] + (scbpa_pkg::ADDR_W'(pop_idx) << lg_ff[g]);

      // free decode
      assign ge        = CMP_W'(offset) >= CMP_W'(lo_ff[g]);
      assign rel       = CMP_W'(offset) - CMP_W'(lo_ff[g]);
      assign inr       = rel < CMP_W'(span_ff[g]);
      assign mask      = (MASK_W'(1) << lg_ff[g]) - MASK_W'(1);
      assign aligned   = (rel[MASK_W-1:0] & mask) == '0;
      assign hit_w[g]  = ge && inr && aligned;
      assign fidx_w[g] = IDX_W'(rel >> lg_ff[g]);
   end

   // first matching class wins
   always_comb begin
      found         = 1'b0;
      pop_sel       = '0;
      push_sel      = '0;
      pay_out_in    = '0;
      cls_out_in    = '0;
      status_out_in = (kind_ff == scbpa_pkg::KIND_ALLOC) ? scbpa_pkg::STATUS_TOO_LARGE
                                                         : scbpa_pkg::STATUS_BAD_FREE;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         if (!found && ((kind_ff == scbpa_pkg::KIND_ALLOC) ? fit_w[c] : hit_w[c])) begin
            found      = 1'b1;
            cls_out_in = scbpa_pkg::CLASS_W'(c);
            if (kind_ff == scbpa_pkg::KIND_ALLOC) begin
               if (empty_w[c]) begin
                  status_out_in = scbpa_pkg::STATUS_EMPTY;
               end else begin
                  status_out_in = scbpa_pkg::STATUS_OK;
                  pay_out_in    = pay_w[c];
                  pop_sel[c]    = 1'b1;
               end
            end else begin
               if (full_w[c]) begin
                  // stack already full: report instead of overrunning it
                  status_out_in = scbpa_pkg::STATUS_DOUBLE_FREE;
               end else begin
                  status_out_in = scbpa_pkg::STATUS_OK;
                  push_sel[c]   = 1'b1;
               end
            end
         end
      end
   end

   // stacks and layout: refill has priority, else one pop or push
   always_ff @(posedge clock) begin
      if (refill_ff) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            lg_ff[c]       <= lg_eff[c];
            n_ff[c]        <= n_eff[c];
            span_ff[c]     <= span_in[c];
            lo_ff[c]       <= lo_in[c];
            pay_base_ff[c] <= pay_base_in[c];
            top_ff[c]      <= n_eff[c];
            for (int k = 0; k < MAX_BLOCKS; k++) begin
               // index zero ends on top
               stack_ff[c][k] <= (k < int'(n_eff[c])) ? IDX_W'(int'(n_eff[c]) - 1 - k)
                                                      : '0;
            end
         end
      end else if (in_valid_ff) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            if (pop_sel[c]) begin
               top_ff[c] <= top_ff[c] - TOP_W'(1);
            end else if (push_sel[c]) begin
               stack_ff[c][top_ff[c][IDX_W-1:0]] <= fidx_w[c];
               top_ff[c] <= top_ff[c] + TOP_W'(1);
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         pay_out_ff    <= pay_out_in;
         cls_out_ff    <= cls_out_in;
         status_out_ff <= status_out_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_address = pay_out_ff;
   assign rsp_class_used      = cls_out_ff;
   assign rsp_status          = status_out_ff;

endmodule

// ===== design/scbpa_checker.sv =====
// scbpa_checker: port-level assertions for the size-class block pool allocator
// depends on scbpa_pkg; bound to size_class_block_pool_allocator below

module scbpa_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic [scbpa_pkg::ADDR_W-1:0]       rsp_payload_address,
   input logic [scbpa_pkg::CLASS_W-1:0]      rsp_class_used,
   input logic [scbpa_pkg::STATUS_W-1:0]     rsp_status,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic [scbpa_pkg::CSR_IDX_W-1:0]    csr_index
);

   // reset is always followed by a refill cycle
   a_reset_refill: assert property (@(posedge clock) reset |=> busy)
      else $error("no refill after reset");

   // every taken word gives a response after the input and result registers
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("response missing");

   // and no response appears without a request
   a_rsp_caused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("response without request");

   // a register write to a known index refills
   a_cfg_refill: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index <= scbpa_pkg::CSR_BASE)) |=> busy)
      else $error("no refill after register write");

   // a failed request never carries an address, and an unmatched one no class
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != scbpa_pkg::STATUS_OK)) |->
      ((rsp_payload_address == '0) &&
       ((rsp_status == scbpa_pkg::STATUS_EMPTY) ||
        (rsp_status == scbpa_pkg::STATUS_DOUBLE_FREE) || (rsp_class_used == '0))))
      else $error("failed response carries address or class");

endmodule

bind size_class_block_pool_allocator scbpa_checker u_scbpa_checker (.*);

// ===== tb/size_class_block_pool_allocator_test.sv =====
// size_class_block_pool_allocator_test: self-checking bench for the size-class pool allocator
// drives alloc and free words against its own pool predictor; depends on scbpa_pkg and the rtl

module size_class_block_pool_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLASS_COUNT    = scbpa_pkg::NUM_CLASSES_DEF;
   localparam int BLOCKS         = scbpa_pkg::MAX_BLOCKS_DEF;
   localparam int NUM_PHASES     = 12;
   localparam int PHASE_ITEMS    = 140;
   localparam int OPENING_ROWS   = 24;
   localparam int LATENCY_TAIL   = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   // an index that no register answers to
   localparam logic [scbpa_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 4'hF;

   typedef struct packed {
      logic [scbpa_pkg::ADDR_W-1:0]  payload;
      logic [scbpa_pkg::CLASS_W-1:0] cls;
      scbpa_pkg::status_type         status;
   } alloc_word_type;

   typedef struct {
      logic                         kind;
      logic [scbpa_pkg::SIZE_W-1:0] size;
      logic [scbpa_pkg::ADDR_W-1:0] address;
      bit                           typed;
      alloc_word_type               reply;
   } opening_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             start            = 1'b0;
   logic                             busy;
   logic                             req_kind         = scbpa_pkg::KIND_ALLOC;
   logic [scbpa_pkg::SIZE_W-1:0]     req_size         = '0;
   logic [scbpa_pkg::ADDR_W-1:0]     req_free_address = '0;
   logic                             rsp_valid;
   logic [scbpa_pkg::ADDR_W-1:0]     rsp_payload_address;
   logic [scbpa_pkg::CLASS_W-1:0]    rsp_class_used;
   logic [scbpa_pkg::STATUS_W-1:0]   rsp_status;
   logic                             csr_valid        = 1'b0;
   logic                             csr_ready;
   logic [scbpa_pkg::CSR_IDX_W-1:0]  csr_index        = '0;
   logic [scbpa_pkg::CSR_DATA_W-1:0] csr_wdata        = '0;

   size_class_block_pool_allocator dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_size            (req_size),
      .req_free_address    (req_free_address),
      .rsp_valid           (rsp_valid),
      .rsp_payload_address (rsp_payload_address),
      .rsp_class_used      (rsp_class_used),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // pool predictor: register copies, per-class free stacks and their tops
   // ---------------------------------------------------------------------------
   logic [scbpa_pkg::LOG2_W-1:0]  log2_reg  [CLASS_COUNT];
   logic [scbpa_pkg::COUNT_W-1:0] count_reg [CLASS_COUNT];
   logic [scbpa_pkg::HDR_W-1:0]   header_reg;
   logic [scbpa_pkg::ADDR_W-1:0]  base_reg;
   logic [2:0]                    free_list [CLASS_COUNT][BLOCKS];
   logic [3:0]                    free_top  [CLASS_COUNT];

   // words the block still owes us, oldest first
   alloc_word_type               pending_outcomes[$];
   // payload addresses handed out and not yet given back
   logic [scbpa_pkg::ADDR_W-1:0] live_blocks[$];

   int fail_count    = 0;
   int items_sent    = 0;
   int replies_seen  = 0;
   int csr_writes    = 0;
   int drains        = 0;
   int status_seen[5] = '{default: 0};

   // block size log2 after clamping to the legal range
   function automatic int unsigned block_shift(input int c);
      if (log2_reg[c] < scbpa_pkg::LOG2_MIN) return scbpa_pkg::LOG2_MIN;
      if (log2_reg[c] > scbpa_pkg::LOG2_MAX) return scbpa_pkg::LOG2_MAX;
      return log2_reg[c];
   endfunction

   function automatic int unsigned block_total(input int c);
      return (count_reg[c] > BLOCKS) ? BLOCKS : count_reg[c];
   endfunction

   // byte offset of a pool from the base address
   function automatic longint unsigned pool_offset(input int c);
      longint unsigned s;
      s = 0;
      for (int k = 0; k < c; k++) s += longint'(block_total(k)) << block_shift(k);
      return s;
   endfunction

   // every stack full again, block zero on top
   function automatic void restock_pools();
      int unsigned n;
      for (int c = 0; c < CLASS_COUNT; c++) begin
         n = block_total(c);
         for (int k = 0; k < BLOCKS; k++) free_list[c][k] = (k < n) ? 3'(n - 1 - k) : 3'd0;
         free_top[c] = 4'(n);
      end
   endfunction

   function automatic logic [scbpa_pkg::ADDR_W-1:0] block_payload(input int c, input int k);
      return scbpa_pkg::ADDR_W'(longint'(base_reg) + pool_offset(c)
                                + (longint'(k) << block_shift(c)) + longint'(header_reg));
   endfunction

   // only the low nibble matters for the small registers
   function automatic void apply_register(input logic [scbpa_pkg::CSR_IDX_W-1:0] idx,
                                          input logic [scbpa_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         scbpa_pkg::CSR_CLASS0_LOG2:  log2_reg[0]  = data[3:0];
         scbpa_pkg::CSR_CLASS1_LOG2:  log2_reg[1]  = data[3:0];
         scbpa_pkg::CSR_CLASS2_LOG2:  log2_reg[2]  = data[3:0];
         scbpa_pkg::CSR_CLASS0_COUNT: count_reg[0] = data[3:0];
         scbpa_pkg::CSR_CLASS1_COUNT: count_reg[1] = data[3:0];
         scbpa_pkg::CSR_CLASS2_COUNT: count_reg[2] = data[3:0];
         scbpa_pkg::CSR_HEADER:       header_reg   = data[3:0];
         scbpa_pkg::CSR_BASE:         base_reg     = data[scbpa_pkg::ADDR_W-1:0];
         default:                     return;
      endcase
      restock_pools();
   endfunction

   // outcome of one request; pops or pushes the chosen stack
   function automatic void pool_outcome(input logic kind,
                                        input logic [scbpa_pkg::SIZE_W-1:0] size,
                                        input logic [scbpa_pkg::ADDR_W-1:0] addr,
                                        output alloc_word_type w);
      int unsigned                  shift, n;
      longint unsigned              bs, lo, rel, off;
      logic [scbpa_pkg::ADDR_W-1:0] distance;
      bit                           done;
      w.payload = '0;
      w.cls     = '0;
      w.status  = scbpa_pkg::STATUS_TOO_LARGE;
      done      = 1'b0;
      if (kind == scbpa_pkg::KIND_ALLOC) begin
         // first class whose block, less the header, holds the size; no fall-through
         for (int c = 0; c < CLASS_COUNT && !done; c++) begin
            shift = block_shift(c);
            bs    = 64'd1 << shift;
            if (longint'(size) + longint'(header_reg) <= bs) begin
               done  = 1'b1;
               w.cls = scbpa_pkg::CLASS_W'(c);
               if (free_top[c] == 4'd0) begin
                  w.status = scbpa_pkg::STATUS_EMPTY;
               end else begin
                  free_top[c] = free_top[c] - 4'd1;
                  w.payload = scbpa_pkg::ADDR_W'(longint'(base_reg) + pool_offset(c)
                              + (longint'(free_list[c][free_top[c]]) << shift)
                              + longint'(header_reg));
                  w.status  = scbpa_pkg::STATUS_OK;
               end
            end
         end
      end else begin
         w.status = scbpa_pkg::STATUS_BAD_FREE;
         distance = addr - base_reg;
         off      = 64'(distance);
         for (int c = 0; c < CLASS_COUNT && !done; c++) begin
            shift = block_shift(c);
            n     = block_total(c);
            bs    = 64'd1 << shift;
            lo    = pool_offset(c) + 64'(header_reg);
            if (off >= lo) begin
               rel = off - lo;
               if (rel < (longint'(n) << shift) && (rel & (bs - 1)) == 0) begin
                  done  = 1'b1;
                  w.cls = scbpa_pkg::CLASS_W'(c);
                  // a full stack rejects the push rather than overrun
                  if (free_top[c] >= n) begin
                     w.status = scbpa_pkg::STATUS_DOUBLE_FREE;
                  end else begin
                     free_list[c][free_top[c]] = 3'(rel >> shift);
                     free_top[c] = free_top[c] + 4'd1;
                     w.status = scbpa_pkg::STATUS_OK;
                  end
               end
            end
         end
      end
   endfunction

   // ---------------------------------------------------------------------------
   // request side: drive on the falling edge, take acceptance on the rising edge
   // ---------------------------------------------------------------------------
   task automatic send_request(input logic kind, input logic [scbpa_pkg::SIZE_W-1:0] size,
                               input logic [scbpa_pkg::ADDR_W-1:0] addr, input bit typed,
                               input alloc_word_type typed_word);
      alloc_word_type predicted;
      @(negedge clock);
      start            <= 1'b1;
      req_kind         <= kind;
      req_size         <= size;
      req_free_address <= addr;
      do @(posedge clock); while (busy);
      pool_outcome(kind, size, addr, predicted);
      // hand-written rows override the predictor but still move its state
      pending_outcomes.push_back(typed ? typed_word : predicted);
      if (kind == scbpa_pkg::KIND_ALLOC && predicted.status == scbpa_pkg::STATUS_OK)
         live_blocks.push_back(predicted.payload);
      items_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // hold off until every owed word has come back
   task automatic wait_for_outcomes();
      @(negedge clock);
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      drains++;
   endtask

   task automatic write_register(input logic [scbpa_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [scbpa_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
      // a refill returns every block, so nothing handed out is live any more
      live_blocks.delete();
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // same nibble into every small register, junk in the unused upper bits
   task automatic write_all_registers(input logic [3:0] nibble,
                                      input logic [scbpa_pkg::ADDR_W-1:0] base);
      for (int r = scbpa_pkg::CSR_CLASS0_LOG2; r <= scbpa_pkg::CSR_HEADER; r++)
         write_register(scbpa_pkg::CSR_IDX_W'(r), {20'($urandom), nibble});
      write_register(scbpa_pkg::CSR_BASE, base);
   endtask

   // mostly well-formed traffic: frees of live blocks, sizes around class edges
   task automatic run_random_phase(input int items, input int idle_pct);
      logic                         kind;
      logic [scbpa_pkg::SIZE_W-1:0] size;
      logic [scbpa_pkg::ADDR_W-1:0] addr;
      int                           pick, c, slot;
      longint                       room;
      alloc_word_type               unused;
      unused = '0;
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(0, 99) < idle_pct) pause_sender($urandom_range(1, 10));
         // flat-out phases never drain mid-stream
         if (idle_pct != 0 && $urandom_range(0, 199) == 0) wait_for_outcomes();
         kind = ($urandom_range(0, 99) < (live_blocks.size() > 4 ? 50 : 35))
                ? scbpa_pkg::KIND_FREE : scbpa_pkg::KIND_ALLOC;
         // the field a request ignores still carries noise
         size = scbpa_pkg::SIZE_W'($urandom);
         addr = scbpa_pkg::ADDR_W'($urandom);
         pick = $urandom_range(0, 99);
         c    = $urandom_range(0, CLASS_COUNT - 1);
         if (kind == scbpa_pkg::KIND_ALLOC) begin
            room = (longint'(1) << block_shift(c)) - longint'(header_reg);
            if (room < 0) room = 0;
            if (pick < 45)      size = scbpa_pkg::SIZE_W'($urandom_range(0, int'(room)));
            else if (pick < 65) size = scbpa_pkg::SIZE_W'(room);
            else if (pick < 80) size = scbpa_pkg::SIZE_W'(room + 1);
            else if (pick < 88) size = scbpa_pkg::SIZE_W'($urandom_range(0, 64));
         end else begin
            if (pick < 55 && live_blocks.size() != 0) begin
               slot = $urandom_range(0, live_blocks.size() - 1);
               addr = live_blocks[slot];
               live_blocks.delete(slot);
            end else if (pick < 80) begin
               // block-shaped address, may be free already or past the count
               addr = block_payload(c, $urandom_range(0, BLOCKS - 1));
            end else if (pick < 90) begin
               addr = block_payload(c, $urandom_range(0, BLOCKS - 1))
                      + scbpa_pkg::ADDR_W'($urandom_range(1, 9)) - scbpa_pkg::ADDR_W'(5);
            end
         end
         send_request(kind, size, addr, 1'b0, unused);
      end
   endtask

   // hand-picked opening words for the reset geometry: 16/32/64 byte blocks, header 8,
   // class 1 from 128, class 2 from 384 up to 640
   opening_row_type opening_rows [OPENING_ROWS] = '{
      '{scbpa_pkg::KIND_ALLOC, 16'd0, 24'd0, 1'b1, '{24'd8, 2'd0, scbpa_pkg::STATUS_OK}},
      '{scbpa_pkg::KIND_ALLOC, 16'd8, 24'hFFFFFF, 1'b1, '{24'd24, 2'd0, scbpa_pkg::STATUS_OK}},
      '{scbpa_pkg::KIND_ALLOC, 16'd9, 24'd0, 1'b1, '{24'd136, 2'd1, scbpa_pkg::STATUS_OK}},
      '{scbpa_pkg::KIND_ALLOC, 16'd56, 24'd0, 1'b1, '{24'd392, 2'd2, scbpa_pkg::STATUS_OK}},
      // nothing holds 57 bytes plus the header
      '{scbpa_pkg::KIND_ALLOC, 16'd57, 24'd0, 1'b1,
        '{24'd0, 2'd0, scbpa_pkg::STATUS_TOO_LARGE}},
      '{scbpa_pkg::KIND_ALLOC, 16'hFFFF, 24'd0, 1'b1,
        '{24'd0, 2'd0, scbpa_pkg::STATUS_TOO_LARGE}},
      '{scbpa_pkg::KIND_FREE, 16'hFFFF, 24'd392, 1'b1, '{24'd0, 2'd2, scbpa_pkg::STATUS_OK}},
      // class 2 stack full again, so the same free bounces
      '{scbpa_pkg::KIND_FREE, 16'd0, 24'd392, 1'b1,
        '{24'd0, 2'd2, scbpa_pkg::STATUS_DOUBLE_FREE}},
      '{scbpa_pkg::KIND_FREE, 16'd0, 24'd0, 1'b1, '{24'd0, 2'd0, scbpa_pkg::STATUS_BAD_FREE}},
      '{scbpa_pkg::KIND_FREE, 16'd0, 24'd9, 1'b1, '{24'd0, 2'd0, scbpa_pkg::STATUS_BAD_FREE}},
      '{scbpa_pkg::KIND_FREE, 16'd0, 24'hFFFFFF, 1'b1,
        '{24'd0, 2'd0, scbpa_pkg::STATUS_BAD_FREE}},
      // one block past the end of class 2
      '{scbpa_pkg::KIND_FREE, 16'd0, 24'd648, 1'b1,
        '{24'd0, 2'd0, scbpa_pkg::STATUS_BAD_FREE}},
      '{scbpa_pkg::KIND_FREE, 16'd0, 24'd24, 1'b0, '{24'd0, 2'd0, scbpa_pkg::STATUS_OK}},
      '{scbpa_pkg::KIND_FREE, 16'd0, 24'd8, 1'b0, '{24'd0, 2'd0, scbpa_pkg::STATUS_OK}},
      '{scbpa_pkg::KIND_FREE, 16'd0, 24'd8, 1'b1,
        '{24'd0, 2'd0, scbpa_pkg::STATUS_DOUBLE_FREE}},
      // drain class 2, then one more finds it empty with no fall-back
      '{scbpa_pkg::KIND_ALLOC, 16'd40, 24'd0, 1'b0, '{24'd0, 2'd0, scbpa_pkg::STATUS_OK}},
      '{scbpa_pkg::KIND_ALLOC, 16'd40, 24'd0, 1'b0, '{24'd0, 2'd0, scbpa_pkg::STATUS_OK}},
      '{scbpa_pkg::KIND_ALLOC, 16'd40, 24'd0, 1'b0, '{24'd0, 2'd0, scbpa_pkg::STATUS_OK}},
      '{scbpa_pkg::KIND_ALLOC, 16'd40, 24'd0, 1'b0, '{24'd0, 2'd0, scbpa_pkg::STATUS_OK}},
      '{scbpa_pkg::KIND_ALLOC, 16'd40, 24'd0, 1'b1, '{24'd0, 2'd2, scbpa_pkg::STATUS_EMPTY}},
      '{scbpa_pkg::KIND_ALLOC, 16'd24, 24'd0, 1'b0, '{24'd0, 2'd0, scbpa_pkg::STATUS_OK}},
      '{scbpa_pkg::KIND_FREE, 16'd0, 24'd136, 1'b0, '{24'd0, 2'd0, scbpa_pkg::STATUS_OK}},
      '{scbpa_pkg::KIND_FREE, 16'd0, 24'd392, 1'b0, '{24'd0, 2'd0, scbpa_pkg::STATUS_OK}},
      '{scbpa_pkg::KIND_ALLOC, 16'd25, 24'd0, 1'b0, '{24'd0, 2'd0, scbpa_pkg::STATUS_OK}}
   };

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int                           idle_pct, wrote;
      logic [scbpa_pkg::ADDR_W-1:0] v;

      // predictor starts from the reset register values with full stacks
      log2_reg   = '{4'd4, 4'd5, 4'd6};
      count_reg  = '{4'd8, 4'd8, 4'd4};
      header_reg = 4'd8;
      base_reg   = '0;
      restock_pools();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed opening; the refill cycle after reset shows up as busy
      for (int i = 0; i < OPENING_ROWS; i++)
         send_request(opening_rows[i].kind, opening_rows[i].size, opening_rows[i].address,
                      opening_rows[i].typed, opening_rows[i].reply);

      for (int p = 1; p <= NUM_PHASES; p++) begin
         // registers only change with the block idle
         wait_for_outcomes();
         if (p == 1) begin
            // smallest blocks, empty pools, no header, base at zero
            write_all_registers(4'h0, '0);
         end else if (p == 2) begin
            // every register at its top, pools wrap past the end of the space
            write_all_registers(4'hF, 24'hFFFFFF);
         end else if (p == 3) begin
            // header fills the class 0 block, so only size zero fits there
            write_register(scbpa_pkg::CSR_CLASS0_LOG2, 24'd3);
            write_register(scbpa_pkg::CSR_HEADER, 24'd8);
            write_register(scbpa_pkg::CSR_BASE, 24'hFFFFF8);
            // unmapped index leaves the stacks alone
            write_register(CSR_UNMAPPED, scbpa_pkg::ADDR_W'($urandom));
         end else begin
            wrote = 0;
            for (int r = scbpa_pkg::CSR_CLASS0_LOG2; r <= scbpa_pkg::CSR_BASE; r++) begin
               if ($urandom_range(0, 1) == 1 || (r == scbpa_pkg::CSR_BASE && wrote == 0)) begin
                  case (scbpa_pkg::csr_index_type'(r))
                     scbpa_pkg::CSR_BASE:
                        v = ($urandom_range(0, 3) == 0) ? (24'hFFFF00 | 24'(8'($urandom)))
                                                        : 24'($urandom);
                     scbpa_pkg::CSR_CLASS0_COUNT, scbpa_pkg::CSR_CLASS1_COUNT,
                     scbpa_pkg::CSR_CLASS2_COUNT:
                        // small pools run dry and fill up often
                        v = {20'($urandom), ($urandom_range(0, 3) == 0) ? 4'($urandom)
                                                                      : 4'($urandom_range(1, 4))};
                     default:
                        v = {20'($urandom), 4'($urandom)};
                  endcase
                  write_register(scbpa_pkg::CSR_IDX_W'(r), v);
                  wrote++;
               end
            end
         end
         // the tail of the run goes flat out
         idle_pct = (p > NUM_PHASES - 2) ? 0 : 10 * $urandom_range(0, 3);
         run_random_phase(PHASE_ITEMS, idle_pct);
      end

      wait_for_outcomes();
      repeat (LATENCY_TAIL) @(posedge clock);

      $display("covered %0d requests over %0d register writes, %0d drains",
               items_sent, csr_writes, drains);
      $display("replies: ok %0d, empty %0d, too large %0d, bad free %0d, double free %0d",
               status_seen[scbpa_pkg::STATUS_OK], status_seen[scbpa_pkg::STATUS_EMPTY],
               status_seen[scbpa_pkg::STATUS_TOO_LARGE], status_seen[scbpa_pkg::STATUS_BAD_FREE],
               status_seen[scbpa_pkg::STATUS_DOUBLE_FREE]);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // reply side: every strobed word is matched against the oldest owed one
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      alloc_word_type want;
      if (!reset && rsp_valid === 1'b1) begin
         replies_seen++;
         if (rsp_status <= scbpa_pkg::STATUS_DOUBLE_FREE) status_seen[rsp_status]++;
         if (pending_outcomes.size() == 0) begin
            $error("reply word with nothing owed: payload_address %h class_used %0d status %0d",
                   rsp_payload_address, rsp_class_used, rsp_status);
            fail_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_payload_address !== want.payload) begin
               $error("payload_address: expected %h, got %h", want.payload, rsp_payload_address);
               fail_count++;
            end
            if (rsp_class_used !== want.cls) begin
               $error("class_used: expected %0d, got %0d", want.cls, rsp_class_used);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // watchdog: too long without any word moving on any channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1 || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles, %0d words still owed",
                  WATCHDOG_LIMIT, pending_outcomes.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
